// ===== src/qtu_pkg.sv =====
`timescale 1ns / 1ps

package qtu_pkg;

  // Kind codes of a command word. The unused code behaves as a query.
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_SET    = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [1:0] CFG_DISCOUNT   = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_Q  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [16:0]        LEARN_RATE_RST = 17'd6554;
  localparam logic [16:0]        DISCOUNT_RST   = 17'd58982;
  localparam logic signed [31:0] DEFAULT_Q_RST  = 32'sd0;

  // A rate of 1.0 in Q1.16.
  localparam logic [16:0] RATE_ONE = 17'd65536;

  // Widths of the multiply-accumulate datapath.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;

  // Command word.
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         state_index;
    logic [2:0]         action_index;
    logic signed [31:0] operand_value;
  } cmd_word_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] entry_value;
    logic signed [31:0] row_max;
    logic [2:0]         best_action;
  } res_word_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

endpackage

// ===== src/q_table_update_engine.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// cmd       in         cmd_valid/cmd_stall  cmd_word_t: kind, state, action, operand
// res       out        res_valid/res_stall  res_word_t: entry, row max, best action
// cfg       in         cfg_write            cfg_index, cfg_data (write only)
//
// An update runs multiply and accumulate steps between the row scan and the write; a
// set or a query does not. The next command can be taken in the same cycle as the
// result appears. The row scan reads one entry per cycle through the single read
// port of the value store, and the update arithmetic runs three products through
// one multiplier. After reset the valid marks are cleared one row per cycle, so no
// command is taken until they are all cleared. A new command is accepted while a
// result still waits; a stalled result holds the block at its last step.

module q_table_update_engine import qtu_pkg::*; #(
  parameter int STATE_COUNT  = 256,
  parameter int ACTION_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_word_t   cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output res_word_t   res,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int RW     = $clog2(STATE_COUNT);
  localparam int AW     = $clog2(ACTION_COUNT);
  localparam int CW     = $clog2(ACTION_COUNT + 1);
  localparam int ADDR_W = $clog2(STATE_COUNT * ACTION_COUNT);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_VROW  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_MUL0  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_WRITE = 4'd8;
  localparam logic [3:0] S_POST  = 4'd9;

  typedef struct packed {
    logic signed [31:0] max_v;
    logic [AW-1:0]      best;
  } pick_t;

  // Reduce a state index by repeated conditional subtraction.
  function automatic logic [7:0] mod_state(input logic [7:0] v);
    logic [24:0] r;
    logic [24:0] d;
    r = 25'(v);
    for (int k = 7; k >= 0; k--) begin
      d = 25'(STATE_COUNT) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[7:0];
  endfunction

  // Reduce an action index the same way.
  function automatic logic [2:0] mod_action(input logic [2:0] v);
    logic [9:0] r;
    logic [9:0] d;
    r = 10'(v);
    for (int k = 2; k >= 0; k--) begin
      d = 10'(ACTION_COUNT) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[2:0];
  endfunction

  // Merge one entry into the maximum of the other entries of its row.
  // Ties keep the lower column, and only values above the floor count.
  function automatic pick_t merge(input logic signed [31:0] v, input logic [AW-1:0] c,
                                  input logic signed [31:0] m, input logic [AW-1:0] b,
                                  input logic signed [31:0] floor_v);
    pick_t p;
    if (v > m) begin
      p.max_v = v;
      p.best  = c;
    end else if (v == m && m > floor_v) begin
      p.max_v = m;
      p.best  = (c < b) ? c : b;
    end else begin
      p.max_v = m;
      p.best  = b;
    end
    return p;
  endfunction

  logic [3:0]         state;
  logic [RW-1:0]      clr_row;
  logic [16:0]        learn_rate;
  logic [16:0]        discount;
  logic signed [31:0] default_q;

  logic [1:0]         kind_q;
  logic [RW-1:0]      row_q;
  logic [AW-1:0]      col_q;
  logic signed [31:0] operand_q;
  logic [CW-1:0]      cnt;
  logic               rd_live;
  logic [AW-1:0]      rd_tag;
  logic signed [31:0] m_ex;
  logic [AW-1:0]      b_ex;
  logic signed [31:0] old_q;
  logic signed [31:0] pre_max_q;
  logic signed [31:0] new_q;

  logic                 accept;
  logic                 issue;
  logic                 res_free;
  logic                 is_update;
  logic                 is_write;
  logic [ADDR_W-1:0]    base;
  logic [16:0]          alpha;
  logic [16:0]          gamma;
  logic [16:0]          keep;
  logic [ADDR_W-1:0]    q_raddr;
  logic [31:0]          q_rdata;
  logic [RW-1:0]        v_raddr;
  logic [ACTION_COUNT-1:0] v_rdata;
  logic [ACTION_COUNT-1:0] vrow_q;
  logic                 v_we;
  logic [RW-1:0]        v_waddr;
  logic [ACTION_COUNT-1:0] v_wdata;
  logic signed [31:0]   write_value;
  logic signed [31:0]   mac_result;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  mac_ctl_t             mac_ctl;
  pick_t                pre_pick;
  pick_t                post_pick;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != S_IDLE);
  assign res_free  = !res_valid || !res_stall;
  assign is_update = (kind_q == KIND_UPDATE);
  assign is_write  = is_update || (kind_q == KIND_SET);
  assign issue     = (state == S_VROW || state == S_SCAN) && (32'(cnt) < ACTION_COUNT);
  assign base      = ADDR_W'(32'(row_q) * ACTION_COUNT);
  assign q_raddr   = base + ADDR_W'(cnt);

  // While idle the valid row of the offered command is read, so it is ready
  // to be captured in the step before the scan.
  assign v_raddr = (state == S_IDLE) ? RW'(mod_state(cmd.state_index)) : row_q;

  // Rates above one count as one.
  assign alpha = (learn_rate > RATE_ONE) ? RATE_ONE : learn_rate;
  assign gamma = (discount > RATE_ONE) ? RATE_ONE : discount;
  assign keep  = RATE_ONE - alpha;

  assign pre_pick  = merge(old_q, col_q, m_ex, b_ex, default_q);
  assign post_pick = merge(new_q, col_q, m_ex, b_ex, default_q);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= LEARN_RATE_RST;
      discount   <= DISCOUNT_RST;
      default_q  <= DEFAULT_Q_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LEARN_RATE: learn_rate <= cfg_data[16:0];
        CFG_DISCOUNT:   discount   <= cfg_data[16:0];
        CFG_DEFAULT_Q:  default_q  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operands and control of the shared multiplier.
  always_comb begin
    mac_ctl = '0;
    mul_a   = old_q;
    mul_b   = $signed({1'b0, keep});
    unique case (state)
      S_MUL0: begin
        mac_ctl.clear  = 1'b1;
        mac_ctl.mul_en = 1'b1;
      end
      S_MUL1: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_en = 1'b1;
        mul_a          = operand_q;
        mul_b          = $signed({1'b0, alpha});
      end
      S_MUL2: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_en = 1'b1;
        mul_a          = pre_max_q;
        mul_b          = $signed({1'b0, gamma});
      end
      S_ACC: begin
        mac_ctl.acc_en = 1'b1;
      end
      default: ;
    endcase
  end

  // Value chosen for the addressed entry.
  always_comb begin
    if (is_update) begin
      write_value = mac_result;
    end else if (kind_q == KIND_SET) begin
      write_value = operand_q;
    end else begin
      write_value = old_q;
    end
  end

  // Valid mark writes: the clearing pass, then marking the written entry.
  always_comb begin
    if (state == S_CLEAR) begin
      v_we    = 1'b1;
      v_waddr = clr_row;
      v_wdata = '0;
    end else begin
      v_we    = (state == S_WRITE) && is_write;
      v_waddr = row_q;
      v_wdata = vrow_q | (ACTION_COUNT'(1) << col_q);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      rd_live   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_live <= issue;
      // The result word is raised at the last step and dropped once taken.
      if (state == S_POST && res_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + RW'(1);
          if (clr_row == RW'(STATE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_VROW;
          end
        end
        S_VROW: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_live && rd_tag == AW'(ACTION_COUNT - 1)) begin
            state <= is_update ? S_MUL0 : S_WRITE;
          end
        end
        S_MUL0:  state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_ACC;
        S_ACC:   state <= S_WRITE;
        S_WRITE: state <= S_POST;
        S_POST: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command capture, row scan and result datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= cmd.kind;
      row_q     <= RW'(mod_state(cmd.state_index));
      col_q     <= AW'(mod_action(cmd.action_index));
      operand_q <= cmd.operand_value;
      cnt       <= '0;
      m_ex      <= default_q;
      b_ex      <= '0;
    end
    if (state == S_VROW) begin
      vrow_q <= v_rdata;
    end
    if (issue) begin
      cnt    <= cnt + CW'(1);
      rd_tag <= cnt[AW-1:0];
    end
    // The addressed entry is held apart; the rest feed the running maximum.
    if (state == S_SCAN && rd_live) begin
      if (rd_tag == col_q) begin
        old_q <= vrow_q[rd_tag] ? $signed(q_rdata) : default_q;
      end else if (vrow_q[rd_tag] && $signed(q_rdata) > m_ex) begin
        m_ex <= $signed(q_rdata);
        b_ex <= rd_tag;
      end
    end
    if (state == S_MUL0) begin
      pre_max_q <= pre_pick.max_v;
    end
    if (state == S_WRITE) begin
      new_q <= write_value;
    end
    if (state == S_POST && res_free) begin
      res.entry_value <= new_q;
      res.row_max     <= post_pick.max_v;
      res.best_action <= 3'(post_pick.best);
    end
  end

  // The row of valid marks is read as the command word is taken.
  qtu_mem #(
    .ROWS (STATE_COUNT),
    .COLS (ACTION_COUNT)
  ) u_mem (
    .clk     (clk),
    .q_raddr (q_raddr),
    .q_rdata (q_rdata),
    .q_we    ((state == S_WRITE) && is_write),
    .q_waddr (base + ADDR_W'(col_q)),
    .q_wdata (write_value),
    .v_raddr (v_raddr),
    .v_rdata (v_rdata),
    .v_we    (v_we),
    .v_waddr (v_waddr),
    .v_wdata (v_wdata)
  );

  qtu_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .result (mac_result)
  );

  // An accepted command keeps the input stalled on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> cmd_stall)
    else $error("command input not stalled after acceptance");

  // A result word only appears at the end of the sequence.
  a_result_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_POST)
    else $error("result word raised outside the final step");

  // Returning scan data always carries a column of the row.
  a_scan_tag_range: assert property (@(posedge clk) disable iff (rst)
    rd_live |-> 32'(rd_tag) < ACTION_COUNT)
    else $error("scan tag beyond the row");

  // Value store writes never overlap the clearing pass.
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !(is_write && $past(state) == S_WRITE))
    else $error("table write during the clearing pass");

endmodule

// ===== src/qtu_mem.sv =====
`timescale 1ns / 1ps

module qtu_mem import qtu_pkg::*; #(
  parameter int ROWS = 256,
  parameter int COLS = 8,
  localparam int ADDR_W = $clog2(ROWS * COLS),
  localparam int ROW_W  = $clog2(ROWS)
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] q_raddr,
  output logic [31:0]       q_rdata,
  input  logic              q_we,
  input  logic [ADDR_W-1:0] q_waddr,
  input  logic [31:0]       q_wdata,
  input  logic [ROW_W-1:0]  v_raddr,
  output logic [COLS-1:0]   v_rdata,
  input  logic              v_we,
  input  logic [ROW_W-1:0]  v_waddr,
  input  logic [COLS-1:0]   v_wdata
);

  logic [31:0]     qmem [ROWS*COLS];
  logic [COLS-1:0] vmem [ROWS];

  // Value store, one entry per state and action.
  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rdata <= qmem[q_raddr];
  end

  // Valid marks, one row of bits per state.
  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    v_rdata <= vmem[v_raddr];
  end

endmodule

// ===== src/qtu_mac.sv =====
`timescale 1ns / 1ps

module qtu_mac import qtu_pkg::*; (
  input  logic                      clk,
  input  mac_ctl_t                  ctl,
  input  logic signed [MUL_A_W-1:0] mul_a,
  input  logic signed [MUL_B_W-1:0] mul_b,
  output logic signed [31:0]        result
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [35:0]       shf;

  // Product register, then accumulation of the previous product.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // Round half up to 16 fractional bits, then saturate to 32 bits.
  always_comb begin
    rnd = acc + ACC_W'(32768);
    shf = 36'(rnd >>> 16);
    if (shf > 36'sd2147483647) begin
      result = 32'sh7FFFFFFF;
    end else if (shf < -36'sd2147483648) begin
      result = 32'sh80000000;
    end else begin
      result = shf[31:0];
    end
  end

endmodule

// ===== dv/q_table_checker.sv =====
`timescale 1ns / 1ps

// Watches the command, result and configuration ports of the Q-table engine.
// It keeps its own copy of the table and the registers, works out the result
// word of every accepted command word, and compares the result words in order.
module q_table_checker import qtu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  logic        cmd_stall,
  input  cmd_word_t   cmd,
  input  logic        res_valid,
  input  logic        res_stall,
  input  res_word_t   res,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  localparam int ROWS = 256;
  localparam int COLS = 8;
  localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

  // Shadow table, valid marks and registers.
  logic signed [31:0] q_mem [ROWS*COLS];
  bit                 q_set [ROWS*COLS];
  logic [16:0]        alpha_reg;
  logic [16:0]        gamma_reg;
  logic signed [31:0] dflt_reg;

  // Result words still owed by the engine, oldest first.
  res_word_t due_words [$];
  int        errs;

  initial begin
    errs = 0;
  end

  // Largest valid entry of a row strictly above the default, lowest column on ties.
  task automatic scan_row(input int row, output logic signed [31:0] top, output int top_col);
    int slot;
    top     = dflt_reg;
    top_col = 0;
    for (int a = 0; a < COLS; a++) begin
      slot = row * COLS + a;
      if (q_set[slot] && q_mem[slot] > top) begin
        top     = q_mem[slot];
        top_col = a;
      end
    end
  endtask

  // Applies one command word to the shadow table and returns its result word.
  task automatic predict_cmd(input cmd_word_t c, output res_word_t r);
    int                 row;
    int                 col;
    int                 slot;
    int                 top_col;
    logic signed [31:0] old_v;
    logic signed [31:0] top;
    longint             alpha;
    longint             gamma;
    longint             acc;
    longint             rnd;
    row  = int'(c.state_index) % ROWS;
    col  = int'(c.action_index) % COLS;
    slot = row * COLS + col;
    case (c.kind)
      KIND_UPDATE: begin
        // Rates above one are used as one.
        alpha = (alpha_reg > RATE_ONE) ? longint'(RATE_ONE) : longint'(alpha_reg);
        gamma = (gamma_reg > RATE_ONE) ? longint'(RATE_ONE) : longint'(gamma_reg);
        old_v = q_set[slot] ? q_mem[slot] : dflt_reg;
        scan_row(row, top, top_col);
        // Exact sum with 32 fraction bits, one rounding half up, then saturation.
        acc = longint'(old_v) * (longint'(RATE_ONE) - alpha)
            + longint'($signed(c.operand_value)) * alpha
            + longint'(top) * gamma;
        rnd = (acc + 64'sd32768) >>> 16;
        if (rnd > SAT_HI) begin
          rnd = SAT_HI;
        end else if (rnd < SAT_LO) begin
          rnd = SAT_LO;
        end
        q_mem[slot] = rnd[31:0];
        q_set[slot] = 1'b1;
      end
      KIND_SET: begin
        q_mem[slot] = c.operand_value;
        q_set[slot] = 1'b1;
      end
      default: begin
        // A query, or the spare kind, leaves the table alone.
      end
    endcase
    scan_row(row, top, top_col);
    r.entry_value = q_set[slot] ? q_mem[slot] : dflt_reg;
    r.row_max     = top;
    r.best_action = top_col[2:0];
  endtask

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    errs++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  // Follow every accepted word on the three ports.
  always @(posedge clk) begin
    res_word_t want;
    res_word_t fresh;
    if (rst) begin
      for (int i = 0; i < ROWS * COLS; i++) begin
        q_set[i] = 1'b0;
      end
      alpha_reg = LEARN_RATE_RST;
      gamma_reg = DISCOUNT_RST;
      dflt_reg  = DEFAULT_Q_RST;
      due_words.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_LEARN_RATE: alpha_reg = cfg_data[16:0];
          CFG_DISCOUNT:   gamma_reg = cfg_data[16:0];
          CFG_DEFAULT_Q:  dflt_reg  = cfg_data;
          default: begin
          end
        endcase
      end
      if (res_valid && !res_stall) begin
        if (due_words.size() == 0) begin
          errs++;
          $display("%0t: result word %h arrived with nothing expected", $time, res);
        end else begin
          want = due_words.pop_front();
          if (res.entry_value !== want.entry_value) begin
            report("entry_value", want.entry_value, res.entry_value);
          end
          if (res.row_max !== want.row_max) begin
            report("row_max", want.row_max, res.row_max);
          end
          if (res.best_action !== want.best_action) begin
            report("best_action", {29'd0, want.best_action}, {29'd0, res.best_action});
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        predict_cmd(cmd, fresh);
        due_words.insert(due_words.size(), fresh);
      end
    end
    mismatches  <= errs;
    outstanding <= due_words.size();
  end

endmodule

// ===== dv/tb_q_table_update_engine.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the Q-table engine; the checker does the predicting.
module tb_q_table_update_engine import qtu_pkg::*;;

  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam int         STALL_LIMIT = 4000;
  localparam int         TAIL_CYCLES = 48;
  localparam int         PHASES      = 6;
  localparam int         PHASE_ITEMS = 182;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_word_t   cmd_word = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_word_t   res_word;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_LEARN_RATE;
  logic [31:0] cfg_data = '0;

  int          mismatches;
  int          outstanding;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  logic [31:0] cur_default = DEFAULT_Q_RST;
  int          hot_rows [6];

  q_table_update_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  q_table_checker q_check (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd_word),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res_word),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The result side stalls now and then, except in the calm stretch.
  always @(negedge clk) begin
    res_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 14);
  end

  // Ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offers one command word, with a random gap in front, and waits until taken.
  task automatic issue_cmd(input logic [1:0] k, input int s, input int a, input logic [31:0] v);
    while (!calm && $urandom_range(0, 99) < 14) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid                <= 1'b1;
    cmd_word.kind            <= k;
    cmd_word.state_index     <= s[7:0];
    cmd_word.action_index    <= a[2:0];
    cmd_word.operand_value   <= v;
    @(posedge clk);
    while (cmd_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Drains the engine, then writes all three registers.
  task automatic load_settings(input logic [31:0] a, input logic [31:0] g, input logic [31:0] d);
    cmd_valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    cfg_write <= 1'b1;
    cfg_index <= CFG_LEARN_RATE;
    cfg_data  <= a;
    @(negedge clk);
    cfg_index <= CFG_DISCOUNT;
    cfg_data  <= g;
    @(negedge clk);
    cfg_index <= CFG_DEFAULT_Q;
    cfg_data  <= d;
    @(negedge clk);
    cfg_write   <= 1'b0;
    cur_default = d;
  endtask

  // Operand mix: extremes, values around the default for ties, and noise.
  function automatic logic [31:0] pick_operand();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      case ($urandom_range(0, 4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0001_0000;
      endcase
    end else if (pick < 50) begin
      return cur_default + $urandom_range(0, 600) - 300;
    end else if (pick < 65) begin
      return ($urandom_range(0, 1) == 0) ? cur_default : cur_default + 1;
    end
    return $urandom();
  endfunction

  // Mostly traffic on a few busy rows so they fill up; the rest anywhere.
  task automatic random_cmd();
    int         pick;
    int         row;
    logic [1:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      k = KIND_UPDATE;
    end else if (pick < 70) begin
      k = KIND_SET;
    end else if (pick < 93) begin
      k = KIND_QUERY;
    end else begin
      k = KIND_SPARE;
    end
    if ($urandom_range(0, 99) < 75) begin
      row = hot_rows[$urandom_range(0, 5)];
    end else begin
      row = $urandom_range(0, 255);
    end
    issue_cmd(k, row, $urandom_range(0, 7), pick_operand());
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: unwritten reads, extremes, ties, spare kind.
    issue_cmd(KIND_QUERY, 0, 0, 32'h0000_0000);
    issue_cmd(KIND_SPARE, 255, 7, 32'hFFFF_FFFF);
    issue_cmd(KIND_UPDATE, 0, 0, 32'h7FFF_FFFF);
    issue_cmd(KIND_UPDATE, 0, 1, 32'h8000_0000);
    issue_cmd(KIND_SET, 0, 2, 32'h7FFF_FFFF);
    issue_cmd(KIND_SET, 0, 3, 32'h7FFF_FFFF);
    issue_cmd(KIND_QUERY, 0, 5, 32'h1234_5678);
    issue_cmd(KIND_SET, 1, 7, 32'hFFFF_FFFB);
    issue_cmd(KIND_SET, 1, 4, 32'h0000_0000);
    issue_cmd(KIND_UPDATE, 1, 4, 32'h0001_0000);

    // Both rates at one: saturation high and low.
    load_settings(32'h0001_0000, 32'h0001_0000, 32'hC000_0000);
    issue_cmd(KIND_UPDATE, 0, 2, 32'h7FFF_FFFF);
    issue_cmd(KIND_UPDATE, 3, 0, 32'h8000_0000);
    issue_cmd(KIND_QUERY, 3, 1, 32'h0000_0000);

    // Rates above one, default at the top so nothing is strictly above it.
    load_settings(32'h0001_FFFF, 32'h0001_0001, 32'h7FFF_FFFF);
    issue_cmd(KIND_UPDATE, 4, 6, 32'h0001_E240);
    issue_cmd(KIND_QUERY, 0, 2, 32'h0000_0000);
    issue_cmd(KIND_SET, 4, 1, 32'h7FFF_FFFF);

    // Both rates at zero: an update keeps the old value.
    load_settings(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    issue_cmd(KIND_UPDATE, 0, 0, 32'h7FFF_FFFF);
    issue_cmd(KIND_UPDATE, 5, 5, 32'hFFFF_FFFF);
    issue_cmd(KIND_QUERY, 255, 0, 32'h0000_0000);

    // Random phases, each under its own settings.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: load_settings($urandom_range(0, 65536), $urandom_range(0, 65536),
                         $urandom_range(0, 1 << 19) - (1 << 18));
        1: load_settings(32'h0001_0000, 32'h0000_0000, 32'h8000_0000);
        2: load_settings(32'h0001_FFFF, 32'h0001_FFFF, 32'h7FFF_FFFF);
        3: load_settings($urandom_range(0, 131071), $urandom_range(0, 131071), $urandom());
        4: load_settings(32'h0000_0000, 32'h0001_0000,
                         $urandom_range(0, 1 << 20) - (1 << 19));
        default: load_settings($urandom_range(0, 65536), $urandom_range(0, 65536),
                               32'h0000_0000);
      endcase
      for (int i = 0; i < 6; i++) begin
        hot_rows[i] = $urandom_range(0, 255);
      end
      hot_rows[0] = (phase % 2 == 0) ? 0 : 255;
      calm <= (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_cmd();
      end
    end

    // Drain, let the engine settle, then give the verdict.
    cmd_valid <= 1'b0;
    calm      <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
